// ===== rtl/core/dsht_pkg.sv =====
package dsht_pkg;

    // default sizes
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int CHAIN_DEPTH_DEF = 8;
    localparam int KEY_BITS_DEF    = 31;

    // configuration port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_BIT = 2;
    localparam int CFG_W    = 7;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd8;
    localparam logic REG_BUCKET_COUNT = 1'b0;

    // request commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV,
        ST_SUM,
        ST_MOD,
        ST_LEN_RD,
        ST_LEN_CHK,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_DEL_FIN
    } t_state;

endpackage

// ===== rtl/core/digit_sum_chained_hash_table.sv =====
// channel   | direction | signals                                    | handshake
// ----------+-----------+--------------------------------------------+-------------------------
// request   | in        | i_command, i_key_value                     | start high, busy low
// result    | out       | o_found, o_status, o_bucket_index,         | o_valid, one cycle
//           |           | o_position                                 |
// config    | in/out    | psel, penable, pwrite, paddr, pwdata,      | apb access, pready high
//           |           | prdata, pready                             |
//
// a request runs the binary to bcd conversion of the key, the digit sum at one decimal digit a
// cycle, the remainder by the bucket count at one sum bit a cycle and the length memory read,
// then a read and a compare per chain entry compared and a read and a write per entry moved up
// on delete
// after reset the length memory is cleared one bucket a cycle, busy high
// results are registered in the cycle after the last step; the receiver cannot stall them
module digit_sum_chained_hash_table #(
    parameter int MAX_BUCKETS = dsht_pkg::MAX_BUCKETS_DEF,
    parameter int CHAIN_DEPTH = dsht_pkg::CHAIN_DEPTH_DEF,
    parameter int KEY_BITS    = dsht_pkg::KEY_BITS_DEF,
    localparam int IDX_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
    localparam int LEN_W      = $clog2(CHAIN_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dsht_pkg::PADDR_W-1:0]    paddr,
    input  logic [dsht_pkg::PDATA_W-1:0]    pwdata,
    output logic [dsht_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [dsht_pkg::CMD_W-1:0]      i_command,
    input  logic [KEY_BITS-1:0]             i_key_value,
    // result
    output logic                            o_valid,
    output logic                            o_found,
    output logic [dsht_pkg::STATUS_W-1:0]   o_status,
    output logic [IDX_W-1:0]                o_bucket_index,
    output logic [LEN_W-1:0]                o_position
);

    localparam int NDIG     = (KEY_BITS * 30103) / 100000 + 1;
    localparam int BCD_W    = 4 * NDIG;
    localparam int SUM_W    = $clog2(9 * NDIG + 1);
    localparam int EFF_W    = $clog2(MAX_BUCKETS + 1);
    localparam int REM_W    = $clog2(MAX_BUCKETS) + 1;
    localparam int CMP_W    = (EFF_W > dsht_pkg::CFG_W) ? EFF_W : dsht_pkg::CFG_W;
    localparam int KDEPTH   = MAX_BUCKETS * CHAIN_DEPTH;
    localparam int KADDR_W  = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int STEP_A   = (KEY_BITS > NDIG) ? KEY_BITS : NDIG;
    localparam int STEP_MAX = (STEP_A > SUM_W) ? STEP_A : SUM_W;
    localparam int CNT_W    = $clog2(STEP_MAX);

    // control registers
    dsht_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic             r_valid, n_valid;
    logic [dsht_pkg::CFG_W-1:0] r_bucket_count;

    // payload registers
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [dsht_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic [KEY_BITS-1:0]         r_kshift, n_kshift;
    logic [BCD_W-1:0]            r_bcd, n_bcd;
    logic [SUM_W-1:0]            r_sum, n_sum;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [LEN_W-1:0]            r_i, n_i;
    logic [LEN_W-1:0]            r_pos, n_pos;
    logic                        r_found, n_found;
    logic [dsht_pkg::STATUS_W-1:0] r_status, n_status;

    // memories and their ports
    logic [KEY_BITS-1:0] key_mem [KDEPTH];
    logic [LEN_W-1:0]    len_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0] r_key_rd;
    logic [LEN_W-1:0]    r_len_rd;
    logic                k_we;
    logic [KADDR_W-1:0]  k_waddr, k_raddr;
    logic [KEY_BITS-1:0] k_wdata;
    logic                l_we;
    logic [IDX_W-1:0]    l_waddr;
    logic [LEN_W-1:0]    l_wdata;

    // datapath helpers
    logic [CMP_W-1:0]  cfg_ext;
    logic [EFF_W-1:0]  eff;
    logic [BCD_W-1:0]  bcd_adj;
    logic [REM_W:0]    rem_sh;
    logic [REM_W-1:0]  rem_nx;
    logic [IDX_W-1:0]  bucket;
    logic [LEN_W-1:0]  i_inc;
    logic              cfg_wr;

    function automatic logic [KADDR_W-1:0] kaddr(input logic [IDX_W-1:0] b,
                                                 input logic [LEN_W-1:0] slot);
        return KADDR_W'(b) * KADDR_W'(CHAIN_DEPTH) + KADDR_W'(slot);
    endfunction

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[dsht_pkg::REG_IDX_BIT] == dsht_pkg::REG_BUCKET_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= dsht_pkg::BUCKET_COUNT_RST;
        end else if (cfg_wr) begin
            r_bucket_count <= pwdata[dsht_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (paddr[dsht_pkg::REG_IDX_BIT] == dsht_pkg::REG_BUCKET_COUNT) begin
            prdata = dsht_pkg::PDATA_W'(r_bucket_count);
        end else begin
            prdata = '0;
        end
    end

    // bucket count clamped to 1..MAX_BUCKETS
    assign cfg_ext = CMP_W'(r_bucket_count);

    always_comb begin
        if (cfg_ext == '0) begin
            eff = EFF_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_BUCKETS)) begin
            eff = EFF_W'(MAX_BUCKETS);
        end else begin
            eff = EFF_W'(cfg_ext);
        end
    end

    // double dabble correction, each digit on its own
    always_comb begin
        logic [3:0] dig;
        bcd_adj = r_bcd;
        for (int d = 0; d < NDIG; d++) begin
            dig = r_bcd[4*d +: 4];
            bcd_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    // one restoring step of the remainder
    assign rem_sh = {r_rem, r_sum[SUM_W-1]};
    assign rem_nx = (rem_sh >= (REM_W+1)'(eff)) ? REM_W'(rem_sh - (REM_W+1)'(eff))
                                                : REM_W'(rem_sh);

    assign bucket = r_rem[IDX_W-1:0];
    assign i_inc  = r_i + 1'b1;

    // sequencer next state, memory controls and result
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_valid  = 1'b0;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_kshift = r_kshift;
        n_bcd    = r_bcd;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_len    = r_len;
        n_i      = r_i;
        n_pos    = r_pos;
        n_found  = r_found;
        n_status = r_status;
        k_we     = 1'b0;
        k_waddr  = kaddr(bucket, r_i);
        k_wdata  = r_key;
        k_raddr  = kaddr(bucket, r_i);
        l_we     = 1'b0;
        l_waddr  = bucket;
        l_wdata  = '0;

        case (r_state)
            dsht_pkg::ST_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = r_clr;
                if (r_clr == IDX_W'(MAX_BUCKETS - 1)) begin
                    n_state = dsht_pkg::ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            dsht_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_key    = i_key_value;
                    n_kshift = i_key_value;
                    n_bcd    = '0;
                    n_cnt    = '0;
                    n_state  = dsht_pkg::ST_CONV;
                end
            end
            // binary to bcd, one key bit a cycle
            dsht_pkg::ST_CONV: begin
                n_bcd    = {bcd_adj[BCD_W-2:0], r_kshift[KEY_BITS-1]};
                n_kshift = r_kshift << 1;
                if (r_cnt == CNT_W'(KEY_BITS - 1)) begin
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_state = dsht_pkg::ST_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // digit sum, one digit a cycle
            dsht_pkg::ST_SUM: begin
                n_sum = r_sum + SUM_W'(r_bcd[3:0]);
                n_bcd = r_bcd >> 4;
                if (r_cnt == CNT_W'(NDIG - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = dsht_pkg::ST_MOD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // remainder by bucket count, one sum bit a cycle
            dsht_pkg::ST_MOD: begin
                n_rem = rem_nx;
                n_sum = r_sum << 1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    n_state = dsht_pkg::ST_LEN_RD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dsht_pkg::ST_LEN_RD: begin
                n_state = dsht_pkg::ST_LEN_CHK;
            end
            dsht_pkg::ST_LEN_CHK: begin
                n_len = r_len_rd;
                n_i   = '0;
                case (r_cmd)
                    dsht_pkg::CMD_INSERT: begin
                        n_valid = 1'b1;
                        n_state = dsht_pkg::ST_IDLE;
                        if (r_len_rd >= LEN_W'(CHAIN_DEPTH)) begin
                            n_found  = 1'b0;
                            n_status = dsht_pkg::STATUS_FULL;
                            n_pos    = '0;
                        end else begin
                            k_we     = 1'b1;
                            k_waddr  = kaddr(bucket, r_len_rd);
                            l_we     = 1'b1;
                            l_wdata  = r_len_rd + 1'b1;
                            n_found  = 1'b1;
                            n_status = dsht_pkg::STATUS_OK;
                            n_pos    = r_len_rd + 1'b1;
                        end
                    end
                    dsht_pkg::CMD_DELETE, dsht_pkg::CMD_SEARCH: begin
                        n_state = dsht_pkg::ST_SCAN_RD;
                    end
                    default: begin
                        n_valid  = 1'b1;
                        n_found  = 1'b0;
                        n_status = dsht_pkg::STATUS_ABSENT;
                        n_pos    = '0;
                        n_state  = dsht_pkg::ST_IDLE;
                    end
                endcase
            end
            // chain scan: read an entry, compare it next cycle
            dsht_pkg::ST_SCAN_RD: begin
                if (r_i >= r_len) begin
                    n_valid  = 1'b1;
                    n_found  = 1'b0;
                    n_status = dsht_pkg::STATUS_ABSENT;
                    n_pos    = '0;
                    n_state  = dsht_pkg::ST_IDLE;
                end else begin
                    n_state = dsht_pkg::ST_SCAN_CMP;
                end
            end
            dsht_pkg::ST_SCAN_CMP: begin
                if (r_key_rd == r_key) begin
                    n_pos = i_inc;
                    if (r_cmd == dsht_pkg::CMD_SEARCH) begin
                        n_valid  = 1'b1;
                        n_found  = 1'b1;
                        n_status = dsht_pkg::STATUS_OK;
                        n_state  = dsht_pkg::ST_IDLE;
                    end else begin
                        n_state = dsht_pkg::ST_SH_RD;
                    end
                end else begin
                    n_i     = i_inc;
                    n_state = dsht_pkg::ST_SCAN_RD;
                end
            end
            // move later entries up one place
            dsht_pkg::ST_SH_RD: begin
                k_raddr = kaddr(bucket, i_inc);
                if (i_inc < r_len) begin
                    n_state = dsht_pkg::ST_SH_WR;
                end else begin
                    n_state = dsht_pkg::ST_DEL_FIN;
                end
            end
            dsht_pkg::ST_SH_WR: begin
                k_we    = 1'b1;
                k_wdata = r_key_rd;
                n_i     = i_inc;
                n_state = dsht_pkg::ST_SH_RD;
            end
            dsht_pkg::ST_DEL_FIN: begin
                l_we     = 1'b1;
                l_wdata  = r_len - 1'b1;
                n_valid  = 1'b1;
                n_found  = 1'b1;
                n_status = dsht_pkg::STATUS_OK;
                n_state  = dsht_pkg::ST_IDLE;
            end
            default: begin
                n_state = dsht_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsht_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_kshift <= n_kshift;
        r_bcd    <= n_bcd;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_len    <= n_len;
        r_i      <= n_i;
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // chain key memory
    always_ff @(posedge i_clk) begin
        if (k_we) begin
            key_mem[k_waddr] <= k_wdata;
        end
        r_key_rd <= key_mem[k_raddr];
    end

    // chain length memory
    always_ff @(posedge i_clk) begin
        if (l_we) begin
            len_mem[l_waddr] <= l_wdata;
        end
        r_len_rd <= len_mem[bucket];
    end

    assign busy           = (r_state != dsht_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_status       = r_status;
    assign o_bucket_index = bucket;
    assign o_position     = r_pos;

endmodule

// ===== rtl/core/dsht_checker.sv =====
module dsht_checker #(
    parameter int POS_W = 4
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic                          o_found,
    input logic [dsht_pkg::STATUS_W-1:0] o_status,
    input logic [POS_W-1:0]              o_position
);

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepted request");

    // a result is only given once the block is free again
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result while busy");

    // strobe lasts one cycle
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // found goes with ok status and a nonzero position
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_status == dsht_pkg::STATUS_OK)))
        else $error("found and status disagree");

    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_position != '0)))
        else $error("position disagrees with found");

endmodule

bind digit_sum_chained_hash_table dsht_checker #(
    .POS_W(LEN_W)
) u_dsht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_found    (o_found),
    .o_status   (o_status),
    .o_position (o_position)
);
